// ===== rtl/assert_macros.svh =====
// assertion macros shared by the tokenizer rtl
// no dependencies; compiled out when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define STT_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tokenizer assertion failed");
`define STT_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tokenizer assertion failed");
`else
`define STT_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define STT_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/stt_pkg.sv =====
// types, codes and character helpers for the source text tokenizer
// no dependencies; used by stt_datapath, stt_ctrl and source_text_tokenizer
`default_nettype none
package stt_pkg;

   typedef enum logic [2:0] {
      MODE_IDLE,
      MODE_IDENT,
      MODE_LONG,
      MODE_NUMBER,
      MODE_STRING,
      MODE_EQUAL,
      MODE_DEAD
   } mode_type;

   typedef enum logic [2:0] {
      ST_WAIT,
      ST_HANDLE,
      ST_DUMP,
      ST_FLUSH,
      ST_START,
      ST_FINAL,
      ST_CLEAR
   } state_type;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_LATCH,
      OP_STR_CLOSE,
      OP_STR_CHAR,
      OP_IDENT_APPEND,
      OP_DUMP_ENTRY,
      OP_LONG_CHAR,
      OP_NUM_DIGIT,
      OP_EQ2,
      OP_FLUSH_KW,
      OP_FLUSH_ENTRY,
      OP_FLUSH_LONG,
      OP_FLUSH_NUM,
      OP_FLUSH_EQ,
      OP_START,
      OP_UNTERM,
      OP_CLEAR
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      mode_type mode;
      logic     is_alnum;
      logic     is_digit;
      logic     is_quote;
      logic     is_equal;
      logic     final_flag;
      logic     buf_full;
      logic     idx_top;
      logic     idx_end;
      logic     kw_hit;
      logic     out_free;
   } sts_type;

   localparam logic [4:0] KIND_IDENTCHAR  = 5'd0;
   localparam logic [4:0] KIND_RETURN     = 5'd1;
   localparam logic [4:0] KIND_FN         = 5'd2;
   localparam logic [4:0] KIND_IF         = 5'd3;
   localparam logic [4:0] KIND_INTEGER    = 5'd4;
   localparam logic [4:0] KIND_STRCHAR    = 5'd5;
   localparam logic [4:0] KIND_EMPTYSTR   = 5'd6;
   localparam logic [4:0] KIND_PUNCT_BASE = 5'd7;
   localparam logic [4:0] KIND_EQUAL      = 5'd17;
   localparam logic [4:0] KIND_EQUAL2     = 5'd18;
   localparam logic [4:0] KIND_ERROR      = 5'd19;

   localparam logic [1:0] ERR_NONE       = 2'd0;
   localparam logic [1:0] ERR_UNEXPECTED = 2'd1;
   localparam logic [1:0] ERR_UNTERM     = 2'd2;

   localparam logic [7:0] CH_SPACE      = 8'h20;
   localparam logic [7:0] CH_CR         = 8'h0D;
   localparam logic [7:0] CH_TAB        = 8'h09;
   localparam logic [7:0] CH_LF         = 8'h0A;
   localparam logic [7:0] CH_EQUAL      = 8'h3D;
   localparam logic [7:0] CH_QUOTE      = 8'h22;
   localparam logic [7:0] CH_UNDERSCORE = 8'h5F;

   localparam logic [47:0] KW_RETURN_TEXT = "return";
   localparam logic [15:0] KW_FN_TEXT     = "fn";
   localparam logic [15:0] KW_IF_TEXT     = "if";

   localparam int          PUNCT_COUNT = 10;
   localparam logic [79:0] PUNCT_TEXT  = "(){};+-*/,";

   function automatic logic is_alpha(input logic [7:0] c);
      return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || c == CH_UNDERSCORE;
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= 8'h30 && c <= 8'h39;
   endfunction

   // msb is the hit flag, the rest the token kind
   function automatic logic [5:0] punct_lookup(input logic [7:0] c);
      logic [5:0] r;
      r = '0;
      for (int i = 0; i < PUNCT_COUNT; i++) begin
         if (PUNCT_TEXT[79 - 8 * i -: 8] == c) begin
            r = {1'b1, KIND_PUNCT_BASE + 5'(i)};
         end
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/stt_interfaces.sv =====
// request and response channel interfaces for the source text tokenizer
// no dependencies
`default_nettype none
interface stt_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_in;
   logic       final_byte;

   modport source (output valid, output char_in, output final_byte, input ready);
   modport sink   (input valid, input char_in, input final_byte, output ready);
endinterface

interface stt_rsp_if #(parameter int LINE_BITS = 24);
   logic                 valid;
   logic                 ready;
   logic [4:0]           token_kind;
   logic [7:0]           char_value;
   logic [30:0]          int_value;
   logic                 int_overflow;
   logic                 last_of_token;
   logic [1:0]           error_code;
   logic [LINE_BITS-1:0] line_number;

   modport source (output valid, output token_kind, output char_value, output int_value,
                   output int_overflow, output last_of_token, output error_code,
                   output line_number, input ready);
   modport sink   (input valid, input token_kind, input char_value, input int_value,
                   input int_overflow, input last_of_token, input error_code,
                   input line_number, output ready);
endinterface
`default_nettype wire

// ===== rtl/stt_datapath.sv =====
// tokenizer datapath: lexer state, keyword buffer, accumulator, line counter, result register
// depends on stt_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"
module stt_datapath #(
   parameter int KEYWORD_BUF_LEN = 6,
   parameter int LINE_BITS       = 24
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire stt_pkg::cmd_type     cmd,
   output stt_pkg::sts_type          sts,
   input  wire logic [7:0]           req_char_in,
   input  wire logic                 req_final_byte,
   input  wire logic                 rsp_ready,
   output logic                      rsp_valid,
   output logic [4:0]                rsp_token_kind,
   output logic [7:0]                rsp_char_value,
   output logic [30:0]               rsp_int_value,
   output logic                      rsp_int_overflow,
   output logic                      rsp_last_of_token,
   output logic [1:0]                rsp_error_code,
   output logic [LINE_BITS-1:0]      rsp_line_number
);

   localparam int IDX_W = (KEYWORD_BUF_LEN > 1) ? $clog2(KEYWORD_BUF_LEN) : 1;
   localparam int LEN_W = $clog2(KEYWORD_BUF_LEN + 1);

   logic [7:0]           cur_char_ff, cur_char_in;
   logic                 cur_final_ff, cur_final_in;
   stt_pkg::mode_type    mode_ff, mode_in;
   logic [7:0]           kbuf_ff [KEYWORD_BUF_LEN];
   logic [LEN_W-1:0]     ident_len_ff, ident_len_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic [7:0]           held_char_ff, held_char_in;
   logic                 held_valid_ff, held_valid_in;
   logic [30:0]          accum_ff, accum_in;
   logic                 ovf_ff, ovf_in;
   logic [LINE_BITS-1:0] line_ff, line_in;
   logic                 out_valid_ff;

   logic                 kbuf_we;
   logic [IDX_W-1:0]     kbuf_waddr;
   logic                 emit;
   logic [4:0]           e_kind;
   logic [7:0]           e_char;
   logic [30:0]          e_int;
   logic                 e_ovf;
   logic                 e_last;
   logic [1:0]           e_err;

   logic                 kw_hit;
   logic [4:0]           kw_kind;
   logic                 idx_end;
   logic [7:0]           kbuf_rd;
   logic [5:0]           punct;
   logic [34:0]          num_next;

   // keyword match over the first entries of the buffer
   always_comb begin
      kw_hit  = 1'b0;
      kw_kind = stt_pkg::KIND_RETURN;
      if (ident_len_ff == LEN_W'(2) && kbuf_ff[0] == stt_pkg::KW_FN_TEXT[15:8]
          && kbuf_ff[1] == stt_pkg::KW_FN_TEXT[7:0]) begin
         kw_hit  = 1'b1;
         kw_kind = stt_pkg::KIND_FN;
      end
      if (ident_len_ff == LEN_W'(2) && kbuf_ff[0] == stt_pkg::KW_IF_TEXT[15:8]
          && kbuf_ff[1] == stt_pkg::KW_IF_TEXT[7:0]) begin
         kw_hit  = 1'b1;
         kw_kind = stt_pkg::KIND_IF;
      end
      if (ident_len_ff == LEN_W'(6)
          && kbuf_ff[0] == stt_pkg::KW_RETURN_TEXT[47:40]
          && kbuf_ff[1] == stt_pkg::KW_RETURN_TEXT[39:32]
          && kbuf_ff[2] == stt_pkg::KW_RETURN_TEXT[31:24]
          && kbuf_ff[3] == stt_pkg::KW_RETURN_TEXT[23:16]
          && kbuf_ff[4] == stt_pkg::KW_RETURN_TEXT[15:8]
          && kbuf_ff[5] == stt_pkg::KW_RETURN_TEXT[7:0]) begin
         kw_hit  = 1'b1;
         kw_kind = stt_pkg::KIND_RETURN;
      end
   end

   assign idx_end  = (LEN_W'(idx_ff) + LEN_W'(1)) == ident_len_ff;
   assign kbuf_rd  = kbuf_ff[idx_ff];
   assign punct    = stt_pkg::punct_lookup(cur_char_ff);
   assign num_next = ({4'd0, accum_ff} << 3) + ({4'd0, accum_ff} << 1)
                     + {31'd0, cur_char_ff[3:0]};

   always_comb begin
      sts.mode       = mode_ff;
      sts.is_alnum   = stt_pkg::is_alpha(cur_char_ff) || stt_pkg::is_digit(cur_char_ff);
      sts.is_digit   = stt_pkg::is_digit(cur_char_ff);
      sts.is_quote   = cur_char_ff == stt_pkg::CH_QUOTE;
      sts.is_equal   = cur_char_ff == stt_pkg::CH_EQUAL;
      sts.final_flag = cur_final_ff;
      sts.buf_full   = ident_len_ff == LEN_W'(KEYWORD_BUF_LEN);
      sts.idx_top    = idx_ff == IDX_W'(KEYWORD_BUF_LEN - 1);
      sts.idx_end    = idx_end;
      sts.kw_hit     = kw_hit;
      sts.out_free   = !out_valid_ff || rsp_ready;
   end

   always_comb begin
      cur_char_in   = cur_char_ff;
      cur_final_in  = cur_final_ff;
      mode_in       = mode_ff;
      ident_len_in  = ident_len_ff;
      idx_in        = idx_ff;
      held_char_in  = held_char_ff;
      held_valid_in = held_valid_ff;
      accum_in      = accum_ff;
      ovf_in        = ovf_ff;
      line_in       = line_ff;
      kbuf_we       = 1'b0;
      kbuf_waddr    = ident_len_ff[IDX_W-1:0];
      emit          = 1'b0;
      e_kind        = stt_pkg::KIND_IDENTCHAR;
      e_char        = '0;
      e_int         = '0;
      e_ovf         = 1'b0;
      e_last        = 1'b0;
      e_err         = stt_pkg::ERR_NONE;
      unique case (cmd.op)
         stt_pkg::OP_NONE: begin
         end
         stt_pkg::OP_LATCH: begin
            cur_char_in  = req_char_in;
            cur_final_in = req_final_byte;
         end
         stt_pkg::OP_STR_CLOSE: begin
            emit   = 1'b1;
            e_last = 1'b1;
            if (held_valid_ff) begin
               e_kind = stt_pkg::KIND_STRCHAR;
               e_char = held_char_ff;
            end else begin
               e_kind = stt_pkg::KIND_EMPTYSTR;
            end
            held_valid_in = 1'b0;
            mode_in       = stt_pkg::MODE_IDLE;
         end
         stt_pkg::OP_STR_CHAR: begin
            if (held_valid_ff) begin
               emit   = 1'b1;
               e_kind = stt_pkg::KIND_STRCHAR;
               e_char = held_char_ff;
            end
            held_char_in  = cur_char_ff;
            held_valid_in = 1'b1;
         end
         stt_pkg::OP_IDENT_APPEND: begin
            kbuf_we      = 1'b1;
            ident_len_in = ident_len_ff + LEN_W'(1);
         end
         stt_pkg::OP_DUMP_ENTRY: begin
            emit   = 1'b1;
            e_kind = stt_pkg::KIND_IDENTCHAR;
            e_char = kbuf_rd;
            if (idx_ff == IDX_W'(KEYWORD_BUF_LEN - 1)) begin
               idx_in        = '0;
               ident_len_in  = '0;
               held_char_in  = cur_char_ff;
               held_valid_in = 1'b1;
               mode_in       = stt_pkg::MODE_LONG;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         stt_pkg::OP_LONG_CHAR: begin
            emit         = 1'b1;
            e_kind       = stt_pkg::KIND_IDENTCHAR;
            e_char       = held_char_ff;
            held_char_in = cur_char_ff;
         end
         stt_pkg::OP_NUM_DIGIT: begin
            if (ovf_ff || num_next[34:31] != 4'd0) begin
               ovf_in   = 1'b1;
               accum_in = '0;
            end else begin
               accum_in = num_next[30:0];
            end
         end
         stt_pkg::OP_EQ2: begin
            emit    = 1'b1;
            e_kind  = stt_pkg::KIND_EQUAL2;
            e_last  = 1'b1;
            mode_in = stt_pkg::MODE_IDLE;
         end
         stt_pkg::OP_FLUSH_KW: begin
            emit         = 1'b1;
            e_kind       = kw_kind;
            e_last       = 1'b1;
            ident_len_in = '0;
            mode_in      = stt_pkg::MODE_IDLE;
         end
         stt_pkg::OP_FLUSH_ENTRY: begin
            emit   = 1'b1;
            e_kind = stt_pkg::KIND_IDENTCHAR;
            e_char = kbuf_rd;
            e_last = idx_end;
            if (idx_end) begin
               idx_in       = '0;
               ident_len_in = '0;
               mode_in      = stt_pkg::MODE_IDLE;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         stt_pkg::OP_FLUSH_LONG: begin
            emit          = 1'b1;
            e_kind        = stt_pkg::KIND_IDENTCHAR;
            e_char        = held_char_ff;
            e_last        = 1'b1;
            held_valid_in = 1'b0;
            mode_in       = stt_pkg::MODE_IDLE;
         end
         stt_pkg::OP_FLUSH_NUM: begin
            emit     = 1'b1;
            e_kind   = stt_pkg::KIND_INTEGER;
            e_int    = ovf_ff ? 31'd0 : accum_ff;
            e_ovf    = ovf_ff;
            e_last   = 1'b1;
            accum_in = '0;
            ovf_in   = 1'b0;
            mode_in  = stt_pkg::MODE_IDLE;
         end
         stt_pkg::OP_FLUSH_EQ: begin
            emit    = 1'b1;
            e_kind  = stt_pkg::KIND_EQUAL;
            e_last  = 1'b1;
            mode_in = stt_pkg::MODE_IDLE;
         end
         stt_pkg::OP_START: begin
            if (cur_char_ff == stt_pkg::CH_SPACE || cur_char_ff == stt_pkg::CH_CR
                || cur_char_ff == stt_pkg::CH_TAB) begin
            end else if (cur_char_ff == stt_pkg::CH_LF) begin
               if (line_ff != '1) begin
                  line_in = line_ff + LINE_BITS'(1);
               end
            end else if (punct[5]) begin
               emit   = 1'b1;
               e_kind = punct[4:0];
               e_last = 1'b1;
            end else if (cur_char_ff == stt_pkg::CH_EQUAL) begin
               mode_in = stt_pkg::MODE_EQUAL;
            end else if (cur_char_ff == stt_pkg::CH_QUOTE) begin
               mode_in       = stt_pkg::MODE_STRING;
               held_valid_in = 1'b0;
            end else if (stt_pkg::is_alpha(cur_char_ff)) begin
               mode_in      = stt_pkg::MODE_IDENT;
               kbuf_we      = 1'b1;
               kbuf_waddr   = '0;
               ident_len_in = LEN_W'(1);
            end else if (stt_pkg::is_digit(cur_char_ff)) begin
               mode_in  = stt_pkg::MODE_NUMBER;
               accum_in = {27'd0, cur_char_ff[3:0]};
               ovf_in   = 1'b0;
            end else begin
               emit    = 1'b1;
               e_kind  = stt_pkg::KIND_ERROR;
               e_char  = cur_char_ff;
               e_err   = stt_pkg::ERR_UNEXPECTED;
               mode_in = stt_pkg::MODE_DEAD;
            end
         end
         stt_pkg::OP_UNTERM: begin
            emit   = 1'b1;
            e_kind = stt_pkg::KIND_ERROR;
            e_err  = stt_pkg::ERR_UNTERM;
         end
         stt_pkg::OP_CLEAR: begin
            mode_in       = stt_pkg::MODE_IDLE;
            ident_len_in  = '0;
            idx_in        = '0;
            held_char_in  = '0;
            held_valid_in = 1'b0;
            accum_in      = '0;
            ovf_in        = 1'b0;
            line_in       = LINE_BITS'(1);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_final_ff  <= 1'b0;
         mode_ff       <= stt_pkg::MODE_IDLE;
         ident_len_ff  <= '0;
         idx_ff        <= '0;
         held_char_ff  <= '0;
         held_valid_ff <= 1'b0;
         accum_ff      <= '0;
         ovf_ff        <= 1'b0;
         line_ff       <= LINE_BITS'(1);
         out_valid_ff  <= 1'b0;
      end else begin
         cur_final_ff  <= cur_final_in;
         mode_ff       <= mode_in;
         ident_len_ff  <= ident_len_in;
         idx_ff        <= idx_in;
         held_char_ff  <= held_char_in;
         held_valid_ff <= held_valid_in;
         accum_ff      <= accum_in;
         ovf_ff        <= ovf_in;
         line_ff       <= line_in;
         if (emit) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cur_char_ff <= cur_char_in;
      if (kbuf_we) begin
         kbuf_ff[kbuf_waddr] <= cur_char_ff;
      end
      if (emit) begin
         rsp_token_kind    <= e_kind;
         rsp_char_value    <= e_char;
         rsp_int_value     <= e_int;
         rsp_int_overflow  <= e_ovf;
         rsp_last_of_token <= e_last;
         rsp_error_code    <= e_err;
         rsp_line_number   <= line_ff;
      end
   end

   assign rsp_valid = out_valid_ff;

   `STT_ASSERT_IMP(a_idx_in_range, clock, reset, 1'b1, idx_ff <= IDX_W'(KEYWORD_BUF_LEN - 1))
   `STT_ASSERT_IMP(a_len_only_in_ident, clock, reset, mode_ff != stt_pkg::MODE_IDENT,
                   ident_len_ff == '0)
   `STT_ASSERT_IMP(a_accum_only_in_number, clock, reset, mode_ff != stt_pkg::MODE_NUMBER,
                   accum_ff == '0 && !ovf_ff)

endmodule
`default_nettype wire

// ===== rtl/stt_ctrl.sv =====
// tokenizer controller: sequences one byte through handle, dump, flush, start, final and clear steps
// depends on stt_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"
module stt_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   output stt_pkg::cmd_type      cmd,
   input  wire stt_pkg::sts_type sts
);

   stt_pkg::state_type state_ff, state_in;
   logic               phase_ff, phase_in;
   stt_pkg::state_type done_state;
   stt_pkg::state_type after_flush;

   assign done_state  = sts.final_flag ? stt_pkg::ST_FINAL : stt_pkg::ST_WAIT;
   assign after_flush = phase_ff ? stt_pkg::ST_CLEAR : stt_pkg::ST_START;

   // next state
   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      unique case (state_ff)
         stt_pkg::ST_WAIT: begin
            if (req_valid) begin
               state_in = stt_pkg::ST_HANDLE;
            end
         end
         stt_pkg::ST_HANDLE: begin
            if (sts.out_free) begin
               case (sts.mode) inside
                  stt_pkg::MODE_DEAD, stt_pkg::MODE_STRING, stt_pkg::MODE_IDLE: begin
                     state_in = done_state;
                  end
                  stt_pkg::MODE_IDENT: begin
                     if (!sts.is_alnum) begin
                        state_in = stt_pkg::ST_FLUSH;
                        phase_in = 1'b0;
                     end else if (sts.buf_full) begin
                        state_in = stt_pkg::ST_DUMP;
                     end else begin
                        state_in = done_state;
                     end
                  end
                  stt_pkg::MODE_LONG: begin
                     state_in = sts.is_alnum ? done_state : stt_pkg::ST_FLUSH;
                     phase_in = 1'b0;
                  end
                  stt_pkg::MODE_NUMBER: begin
                     state_in = sts.is_digit ? done_state : stt_pkg::ST_FLUSH;
                     phase_in = 1'b0;
                  end
                  stt_pkg::MODE_EQUAL: begin
                     state_in = sts.is_equal ? done_state : stt_pkg::ST_FLUSH;
                     phase_in = 1'b0;
                  end
                  default: begin
                     state_in = done_state;
                  end
               endcase
            end
         end
         stt_pkg::ST_DUMP: begin
            if (sts.out_free && sts.idx_top) begin
               state_in = done_state;
            end
         end
         stt_pkg::ST_FLUSH: begin
            if (sts.out_free) begin
               if (sts.mode == stt_pkg::MODE_IDENT && !sts.kw_hit && !sts.idx_end) begin
                  state_in = stt_pkg::ST_FLUSH;
               end else begin
                  state_in = after_flush;
               end
            end
         end
         stt_pkg::ST_START: begin
            if (sts.out_free) begin
               state_in = done_state;
            end
         end
         stt_pkg::ST_FINAL: begin
            if (sts.out_free) begin
               if (sts.mode == stt_pkg::MODE_STRING) begin
                  state_in = stt_pkg::ST_CLEAR;
               end else begin
                  state_in = stt_pkg::ST_FLUSH;
                  phase_in = 1'b1;
               end
            end
         end
         stt_pkg::ST_CLEAR: begin
            state_in = stt_pkg::ST_WAIT;
         end
         default: begin
            state_in = stt_pkg::ST_WAIT;
         end
      endcase
   end

   // outputs
   always_comb begin
      req_ready = 1'b0;
      cmd.op    = stt_pkg::OP_NONE;
      unique case (state_ff)
         stt_pkg::ST_WAIT: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op = stt_pkg::OP_LATCH;
            end
         end
         stt_pkg::ST_HANDLE: begin
            if (sts.out_free) begin
               case (sts.mode)
                  stt_pkg::MODE_STRING: begin
                     cmd.op = sts.is_quote ? stt_pkg::OP_STR_CLOSE : stt_pkg::OP_STR_CHAR;
                  end
                  stt_pkg::MODE_IDENT: begin
                     if (sts.is_alnum && !sts.buf_full) begin
                        cmd.op = stt_pkg::OP_IDENT_APPEND;
                     end
                  end
                  stt_pkg::MODE_LONG: begin
                     if (sts.is_alnum) begin
                        cmd.op = stt_pkg::OP_LONG_CHAR;
                     end
                  end
                  stt_pkg::MODE_NUMBER: begin
                     if (sts.is_digit) begin
                        cmd.op = stt_pkg::OP_NUM_DIGIT;
                     end
                  end
                  stt_pkg::MODE_EQUAL: begin
                     if (sts.is_equal) begin
                        cmd.op = stt_pkg::OP_EQ2;
                     end
                  end
                  stt_pkg::MODE_IDLE: begin
                     cmd.op = stt_pkg::OP_START;
                  end
                  default: begin
                     cmd.op = stt_pkg::OP_NONE;
                  end
               endcase
            end
         end
         stt_pkg::ST_DUMP: begin
            if (sts.out_free) begin
               cmd.op = stt_pkg::OP_DUMP_ENTRY;
            end
         end
         stt_pkg::ST_FLUSH: begin
            if (sts.out_free) begin
               case (sts.mode)
                  stt_pkg::MODE_IDENT: begin
                     cmd.op = sts.kw_hit ? stt_pkg::OP_FLUSH_KW : stt_pkg::OP_FLUSH_ENTRY;
                  end
                  stt_pkg::MODE_LONG:   cmd.op = stt_pkg::OP_FLUSH_LONG;
                  stt_pkg::MODE_NUMBER: cmd.op = stt_pkg::OP_FLUSH_NUM;
                  stt_pkg::MODE_EQUAL:  cmd.op = stt_pkg::OP_FLUSH_EQ;
                  default:              cmd.op = stt_pkg::OP_NONE;
               endcase
            end
         end
         stt_pkg::ST_START: begin
            if (sts.out_free) begin
               cmd.op = stt_pkg::OP_START;
            end
         end
         stt_pkg::ST_FINAL: begin
            if (sts.out_free && sts.mode == stt_pkg::MODE_STRING) begin
               cmd.op = stt_pkg::OP_UNTERM;
            end
         end
         stt_pkg::ST_CLEAR: begin
            cmd.op = stt_pkg::OP_CLEAR;
         end
         default: begin
            cmd.op = stt_pkg::OP_NONE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= stt_pkg::ST_WAIT;
         phase_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
      end
   end

   `STT_ASSERT_NEXT(a_accept_goes_handle, clock, reset,
                    state_ff == stt_pkg::ST_WAIT && req_valid,
                    state_ff == stt_pkg::ST_HANDLE)
   `STT_ASSERT_IMP(a_no_op_when_blocked, clock, reset,
                   !sts.out_free && state_ff != stt_pkg::ST_WAIT
                   && state_ff != stt_pkg::ST_CLEAR,
                   cmd.op == stt_pkg::OP_NONE)
   `STT_ASSERT_IMP(a_dump_in_ident, clock, reset, state_ff == stt_pkg::ST_DUMP,
                   sts.mode == stt_pkg::MODE_IDENT)

endmodule
`default_nettype wire

// ===== rtl/source_text_tokenizer.sv =====
// one byte beat is taken in ST_WAIT and handled in ST_HANDLE right after it. ending a token
// passes through ST_FLUSH, which gives the token's results one by one, then ST_START to start
// the next; a keyword buffer dump passes through ST_DUMP, giving KEYWORD_BUF_LEN entries. the
// final byte adds ST_FINAL and ST_CLEAR plus ST_FLUSH for any pending results, entered even
// with none pending unless a string is open. one result per cycle leaves the output register; a stall holds all.
// reset is synchronous and active high; the buffer needs no clearing pass.
`default_nettype none
module source_text_tokenizer #(
   parameter int KEYWORD_BUF_LEN = 6,
   parameter int LINE_BITS       = 24
) (
   input wire logic  clock,
   input wire logic  reset,
   stt_req_if.sink   req_ch,
   stt_rsp_if.source rsp_ch
);

   stt_pkg::cmd_type cmd;
   stt_pkg::sts_type sts;

   stt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   stt_datapath #(
      .KEYWORD_BUF_LEN (KEYWORD_BUF_LEN),
      .LINE_BITS       (LINE_BITS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_char_in       (req_ch.char_in),
      .req_final_byte    (req_ch.final_byte),
      .rsp_ready         (rsp_ch.ready),
      .rsp_valid         (rsp_ch.valid),
      .rsp_token_kind    (rsp_ch.token_kind),
      .rsp_char_value    (rsp_ch.char_value),
      .rsp_int_value     (rsp_ch.int_value),
      .rsp_int_overflow  (rsp_ch.int_overflow),
      .rsp_last_of_token (rsp_ch.last_of_token),
      .rsp_error_code    (rsp_ch.error_code),
      .rsp_line_number   (rsp_ch.line_number)
   );

endmodule
`default_nettype wire

// ===== test/source_text_tokenizer_tb.sv =====
// self-checking testbench for the source text tokenizer: byte beats in, token beats out
// depends on rtl/stt_pkg.sv, rtl/stt_interfaces.sv and rtl/source_text_tokenizer.sv
`default_nettype none
module source_text_tokenizer_tb;

   localparam int NAME_BUF_LEN = 6;
   localparam int LINE_W       = 24;

   typedef struct {
      logic [4:0]        kind;
      logic [7:0]        ch;
      logic [30:0]       ival;
      logic              ovf;
      logic              last;
      logic [1:0]        err;
      logic [LINE_W-1:0] line;
   } token_rec_type;

   typedef struct {
      logic [7:0] ch;
      logic       fin;
      bit         drain;
   } src_byte_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic       send_valid = 1'b0;
   logic [7:0] send_char  = '0;
   logic       send_fin   = 1'b0;
   logic       take_ready = 1'b0;

   stt_req_if                     req_ch ();
   stt_rsp_if #(.LINE_BITS(LINE_W)) rsp_ch ();

   assign req_ch.valid      = send_valid;
   assign req_ch.char_in    = send_char;
   assign req_ch.final_byte = send_fin;
   assign rsp_ch.ready      = take_ready;

   source_text_tokenizer #(
      .KEYWORD_BUF_LEN(NAME_BUF_LEN),
      .LINE_BITS      (LINE_W)
   ) u_dut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch)
   );

   always #10 clock = ~clock;

   // lexer shadow state
   stt_pkg::mode_type lex_mode = stt_pkg::MODE_IDLE;
   logic [7:0]        name_buf [0:NAME_BUF_LEN-1];
   int                name_len = 0;
   logic [7:0]        held_ch  = '0;
   bit                held_ok  = 1'b0;
   logic [30:0]       num_acc  = '0;
   bit                num_ovf  = 1'b0;
   logic [LINE_W-1:0] line_cnt = 1;

   token_rec_type tokens_due [$];
   src_byte_type  pending [$];
   logic [7:0]    text_bytes [$];

   int failures       = 0;
   int tokens_checked = 0;
   int error_tokens   = 0;
   int ovf_tokens     = 0;
   int texts_built    = 0;
   int bytes_sent     = 0;
   int gap_left       = 0;
   int stall_left     = 0;
   int calm_tx        = 0;
   int calm_rx        = 0;

   function automatic bit is_letter(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == stt_pkg::CH_UNDERSCORE;
   endfunction

   function automatic bit is_numeral(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic int punct_index(input logic [7:0] c);
      case (c)
         "(": return 0;
         ")": return 1;
         "{": return 2;
         "}": return 3;
         ";": return 4;
         "+": return 5;
         "-": return 6;
         "*": return 7;
         "/": return 8;
         ",": return 9;
         default: return -1;
      endcase
   endfunction

   task automatic emit_token(input logic [4:0] kind, input logic [7:0] ch,
                             input logic [30:0] ival, input logic ovf,
                             input logic last, input logic [1:0] err);
      token_rec_type t;
      t.kind = kind;
      t.ch   = ch;
      t.ival = ival;
      t.ovf  = ovf;
      t.last = last;
      t.err  = err;
      t.line = line_cnt;
      tokens_due.push_back(t);
   endtask

   task automatic reset_lexer();
      lex_mode = stt_pkg::MODE_IDLE;
      name_len = 0;
      held_ch  = '0;
      held_ok  = 1'b0;
      num_acc  = '0;
      num_ovf  = 1'b0;
      line_cnt = 1;
   endtask

   task automatic close_token();
      bit         hit;
      logic [4:0] kw;
      hit = 1'b0;
      kw  = stt_pkg::KIND_IDENTCHAR;
      case (lex_mode)
         stt_pkg::MODE_IDENT: begin
            if (name_len == 6 && {name_buf[0], name_buf[1], name_buf[2], name_buf[3],
                                  name_buf[4], name_buf[5]} == stt_pkg::KW_RETURN_TEXT) begin
               hit = 1'b1;
               kw  = stt_pkg::KIND_RETURN;
            end else if (name_len == 2 && {name_buf[0], name_buf[1]} == stt_pkg::KW_FN_TEXT) begin
               hit = 1'b1;
               kw  = stt_pkg::KIND_FN;
            end else if (name_len == 2 && {name_buf[0], name_buf[1]} == stt_pkg::KW_IF_TEXT) begin
               hit = 1'b1;
               kw  = stt_pkg::KIND_IF;
            end
            if (hit) begin
               emit_token(kw, 8'd0, 31'd0, 1'b0, 1'b1, stt_pkg::ERR_NONE);
            end else begin
               for (int i = 0; i < name_len; i++)
                  emit_token(stt_pkg::KIND_IDENTCHAR, name_buf[i], 31'd0, 1'b0,
                             i + 1 == name_len, stt_pkg::ERR_NONE);
            end
            name_len = 0;
            lex_mode = stt_pkg::MODE_IDLE;
         end
         stt_pkg::MODE_LONG: begin
            emit_token(stt_pkg::KIND_IDENTCHAR, held_ch, 31'd0, 1'b0, 1'b1, stt_pkg::ERR_NONE);
            held_ok  = 1'b0;
            lex_mode = stt_pkg::MODE_IDLE;
         end
         stt_pkg::MODE_NUMBER: begin
            emit_token(stt_pkg::KIND_INTEGER, 8'd0, num_ovf ? 31'd0 : num_acc, num_ovf, 1'b1,
                       stt_pkg::ERR_NONE);
            num_acc  = '0;
            num_ovf  = 1'b0;
            lex_mode = stt_pkg::MODE_IDLE;
         end
         stt_pkg::MODE_EQUAL: begin
            emit_token(stt_pkg::KIND_EQUAL, 8'd0, 31'd0, 1'b0, 1'b1, stt_pkg::ERR_NONE);
            lex_mode = stt_pkg::MODE_IDLE;
         end
         default: ;
      endcase
   endtask

   task automatic open_token(input logic [7:0] c);
      int p;
      p = punct_index(c);
      if (c == stt_pkg::CH_SPACE || c == stt_pkg::CH_CR || c == stt_pkg::CH_TAB) begin
      end else if (c == stt_pkg::CH_LF) begin
         if (line_cnt != {LINE_W{1'b1}})
            line_cnt = line_cnt + 1'b1;
      end else if (p >= 0) begin
         emit_token(stt_pkg::KIND_PUNCT_BASE + 5'(p), 8'd0, 31'd0, 1'b0, 1'b1,
                    stt_pkg::ERR_NONE);
      end else if (c == stt_pkg::CH_EQUAL) begin
         lex_mode = stt_pkg::MODE_EQUAL;
      end else if (c == stt_pkg::CH_QUOTE) begin
         lex_mode = stt_pkg::MODE_STRING;
         held_ok  = 1'b0;
      end else if (is_letter(c)) begin
         lex_mode    = stt_pkg::MODE_IDENT;
         name_buf[0] = c;
         name_len    = 1;
      end else if (is_numeral(c)) begin
         lex_mode = stt_pkg::MODE_NUMBER;
         num_acc  = 31'(c - "0");
         num_ovf  = 1'b0;
      end else begin
         emit_token(stt_pkg::KIND_ERROR, c, 31'd0, 1'b0, 1'b0, stt_pkg::ERR_UNEXPECTED);
         lex_mode = stt_pkg::MODE_DEAD;
      end
   endtask

   // expected tokens for one accepted byte
   task automatic take_byte(input logic [7:0] c, input logic fin);
      bit          done;
      logic [63:0] wide;
      done = 1'b0;
      case (lex_mode)
         stt_pkg::MODE_DEAD: done = 1'b1;
         stt_pkg::MODE_STRING: begin
            done = 1'b1;
            if (c == stt_pkg::CH_QUOTE) begin
               if (held_ok)
                  emit_token(stt_pkg::KIND_STRCHAR, held_ch, 31'd0, 1'b0, 1'b1,
                             stt_pkg::ERR_NONE);
               else
                  emit_token(stt_pkg::KIND_EMPTYSTR, 8'd0, 31'd0, 1'b0, 1'b1,
                             stt_pkg::ERR_NONE);
               held_ok  = 1'b0;
               lex_mode = stt_pkg::MODE_IDLE;
            end else begin
               if (held_ok)
                  emit_token(stt_pkg::KIND_STRCHAR, held_ch, 31'd0, 1'b0, 1'b0,
                             stt_pkg::ERR_NONE);
               held_ch = c;
               held_ok = 1'b1;
            end
         end
         stt_pkg::MODE_IDENT: begin
            if (is_letter(c) || is_numeral(c)) begin
               done = 1'b1;
               if (name_len < NAME_BUF_LEN) begin
                  name_buf[name_len] = c;
                  name_len++;
               end else begin
                  for (int i = 0; i < NAME_BUF_LEN; i++)
                     emit_token(stt_pkg::KIND_IDENTCHAR, name_buf[i], 31'd0, 1'b0, 1'b0,
                                stt_pkg::ERR_NONE);
                  name_len = 0;
                  held_ch  = c;
                  held_ok  = 1'b1;
                  lex_mode = stt_pkg::MODE_LONG;
               end
            end
         end
         stt_pkg::MODE_LONG: begin
            if (is_letter(c) || is_numeral(c)) begin
               done = 1'b1;
               emit_token(stt_pkg::KIND_IDENTCHAR, held_ch, 31'd0, 1'b0, 1'b0,
                          stt_pkg::ERR_NONE);
               held_ch = c;
            end
         end
         stt_pkg::MODE_NUMBER: begin
            if (is_numeral(c)) begin
               done = 1'b1;
               wide = 64'(num_acc) * 64'd10 + 64'(c - "0");
               if (num_ovf || wide > 64'h7FFF_FFFF) begin
                  num_ovf = 1'b1;
                  num_acc = '0;
               end else begin
                  num_acc = wide[30:0];
               end
            end
         end
         stt_pkg::MODE_EQUAL: begin
            if (c == stt_pkg::CH_EQUAL) begin
               done = 1'b1;
               emit_token(stt_pkg::KIND_EQUAL2, 8'd0, 31'd0, 1'b0, 1'b1, stt_pkg::ERR_NONE);
               lex_mode = stt_pkg::MODE_IDLE;
            end
         end
         default: ;
      endcase
      if (!done) begin
         close_token();
         open_token(c);
      end
      if (fin) begin
         if (lex_mode == stt_pkg::MODE_STRING)
            emit_token(stt_pkg::KIND_ERROR, 8'd0, 31'd0, 1'b0, 1'b0, stt_pkg::ERR_UNTERM);
         else
            close_token();
         reset_lexer();
      end
   endtask

   // mostly short gaps, a few long ones, and now and then a stretch with none
   function automatic int idle_len(inout int calm);
      int r;
      r = $urandom_range(0, 99);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if (r < 4) begin
         calm = $urandom_range(15, 40);
         return 0;
      end
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      return $urandom_range(6, 25);
   endfunction

   function automatic logic [7:0] rand_letter();
      int r;
      r = $urandom_range(0, 52);
      if (r < 26) return 8'("a" + r);
      if (r < 52) return 8'("A" + r - 26);
      return stt_pkg::CH_UNDERSCORE;
   endfunction

   function automatic logic [7:0] rand_alnum();
      if ($urandom_range(0, 3) == 0) return 8'("0" + $urandom_range(0, 9));
      return rand_letter();
   endfunction

   task automatic put_str(input string s);
      for (int i = 0; i < s.len(); i++)
         text_bytes.push_back(s[i]);
   endtask

   task automatic put_text(input bit drain);
      src_byte_type b;
      for (int i = 0; i < text_bytes.size(); i++) begin
         b.ch    = text_bytes[i];
         b.fin   = (i == text_bytes.size() - 1);
         b.drain = drain && (i == 0);
         pending.push_back(b);
      end
      text_bytes.delete();
      texts_built++;
   endtask

   task automatic add_random_token();
      int         pick;
      int         n;
      logic [7:0] c;
      string      marks;
      string      spaces;
      marks  = "(){};+-*/,";
      spaces = " \t\r\n";
      pick   = $urandom_range(0, 99);
      if (pick < 12) begin
         case ($urandom_range(0, 2))
            0: put_str("return");
            1: put_str("fn");
            default: put_str("if");
         endcase
      end else if (pick < 30) begin
         if ($urandom_range(0, 3) == 0) begin
            if ($urandom_range(0, 1))
               put_str("return");
            else
               put_str("if");
            text_bytes.push_back(rand_alnum());
         end else begin
            n = $urandom_range(0, 3) == 0 ? $urandom_range(6, 12) : $urandom_range(1, 5);
            text_bytes.push_back(rand_letter());
            for (int i = 1; i < n; i++)
               text_bytes.push_back(rand_alnum());
         end
      end else if (pick < 45) begin
         case ($urandom_range(0, 9))
            0: put_str("2147483647");
            1: put_str("2147483648");
            2: begin
               n = $urandom_range(11, 13);
               for (int i = 0; i < n; i++)
                  text_bytes.push_back(8'("0" + $urandom_range(0, 9)));
            end
            default: begin
               n = $urandom_range(1, 5);
               for (int i = 0; i < n; i++)
                  text_bytes.push_back(8'("0" + $urandom_range(0, 9)));
            end
         endcase
      end else if (pick < 58) begin
         text_bytes.push_back(stt_pkg::CH_QUOTE);
         n = $urandom_range(0, 6);
         for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 7) == 0) begin
               c = stt_pkg::CH_LF;
            end else begin
               do c = 8'($urandom_range(0, 255)); while (c == stt_pkg::CH_QUOTE);
            end
            text_bytes.push_back(c);
         end
         text_bytes.push_back(stt_pkg::CH_QUOTE);
      end else if (pick < 78) begin
         text_bytes.push_back(marks[$urandom_range(0, 9)]);
      end else if (pick < 88) begin
         if ($urandom_range(0, 1))
            put_str("=");
         else
            put_str("==");
      end else begin
         n = $urandom_range(1, 3);
         for (int i = 0; i < n; i++)
            text_bytes.push_back(spaces[$urandom_range(0, 3)]);
      end
      if ($urandom_range(0, 1) == 0)
         text_bytes.push_back($urandom_range(0, 2) ? stt_pkg::CH_SPACE : stt_pkg::CH_LF);
      if ($urandom_range(0, 99) < 3)
         text_bytes.push_back(8'($urandom_range(0, 255)));
   endtask

   task automatic check_token();
      token_rec_type want;
      if (rsp_ch.token_kind == stt_pkg::KIND_ERROR) error_tokens++;
      if (rsp_ch.int_overflow) ovf_tokens++;
      if (tokens_due.size() == 0) begin
         $display("%0t: token beat with nothing expected: got kind=%0d char=%02h int=%0d",
                  $time, rsp_ch.token_kind, rsp_ch.char_value, rsp_ch.int_value);
         failures++;
      end else begin
         want = tokens_due.pop_front();
         tokens_checked++;
         if (rsp_ch.token_kind !== want.kind || rsp_ch.char_value !== want.ch ||
             rsp_ch.int_value !== want.ival || rsp_ch.int_overflow !== want.ovf ||
             rsp_ch.last_of_token !== want.last || rsp_ch.error_code !== want.err ||
             rsp_ch.line_number !== want.line) begin
            $display("%0t: expected kind=%0d ch=%02h int=%0d ovf=%0b last=%0b err=%0d line=%0d",
                     $time, want.kind, want.ch, want.ival, want.ovf, want.last, want.err,
                     want.line);
            $display("%0t: actual   kind=%0d ch=%02h int=%0d ovf=%0b last=%0b err=%0d line=%0d",
                     $time, rsp_ch.token_kind, rsp_ch.char_value, rsp_ch.int_value,
                     rsp_ch.int_overflow, rsp_ch.last_of_token, rsp_ch.error_code,
                     rsp_ch.line_number);
            failures++;
         end
      end
   endtask

   // byte driver
   always @(posedge clock) begin
      src_byte_type nxt;
      if (reset) begin
         send_valid <= 1'b0;
         gap_left = 0;
      end else begin
         if (send_valid && req_ch.ready) begin
            take_byte(send_char, send_fin);
            bytes_sent++;
         end
         if (!send_valid || req_ch.ready) begin
            if (gap_left > 0) begin
               gap_left--;
               send_valid <= 1'b0;
            end else if (pending.size() > 0 &&
                         !(pending[0].drain && tokens_due.size() > 0)) begin
               nxt = pending.pop_front();
               send_char  <= nxt.ch;
               send_fin   <= nxt.fin;
               send_valid <= 1'b1;
               gap_left = idle_len(calm_tx);
            end else begin
               send_valid <= 1'b0;
            end
         end
      end
   end

   // token monitor
   always @(posedge clock) begin
      if (reset) begin
         take_ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_ch.valid && take_ready)
            check_token();
         if (stall_left > 0) begin
            stall_left--;
            take_ready <= 1'b0;
         end else begin
            take_ready <= 1'b1;
            if ($urandom_range(0, 99) < 20)
               stall_left = idle_len(calm_rx);
         end
      end
   end

   initial begin
      // keywords, whitespace, newline, equal2 at the final byte
      put_str("return\tfn\nif==");
      put_text(1'b0);
      // equal ended by a quote, empty string, unexpected byte then dropped byte
      put_str("x=\"\"");
      text_bytes.push_back(8'hFF);
      text_bytes.push_back(8'h00);
      put_text(1'b0);
      // long name, integer, string left open at the final byte
      put_str("abcdefg,7\"q");
      put_text(1'b0);

      while (pending.size() < 200) begin
         for (int i = $urandom_range(1, 12); i > 0; i--)
            add_random_token();
         if ($urandom_range(0, 99) < 15) begin
            text_bytes.push_back(stt_pkg::CH_QUOTE);
            for (int i = $urandom_range(0, 3); i > 0; i--)
               text_bytes.push_back(rand_alnum());
         end
         put_text(texts_built % 5 == 3);
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      while (pending.size() != 0 || send_valid || tokens_due.size() != 0)
         @(posedge clock);
      repeat (40) @(posedge clock);

      $display("ran %0d texts, %0d bytes; %0d tokens checked, %0d errors, %0d overflows",
               texts_built, bytes_sent, tokens_checked, error_tokens, ovf_tokens);
      if (failures == 0 && tokens_due.size() == 0) begin
         $display("source_text_tokenizer test passed");
      end else begin
         $display("source_text_tokenizer test failed");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("timeout with %0d tokens outstanding", tokens_due.size());
      $display("source_text_tokenizer test failed");
      $finish;
   end

endmodule
`default_nettype wire
